### hdl/fssp_pkg.sv
// Shared constants and types for the fair-share stream picker.
package fssp_pkg;

   localparam int NUM_STREAMS = 4;
   localparam int STREAM_W    = 2;
   localparam int USAGE_W     = 32;
   localparam int TIME_W      = 32;
   localparam int BACKOFF_W   = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [STREAM_W-1:0]  LAST_STREAM = STREAM_W'(NUM_STREAMS - 1);
   localparam logic [USAGE_W-1:0]   STRIDE_RESET = 32'd65536;
   localparam logic [USAGE_W-1:0]   LIMIT_RESET  = 32'd32768000;
   localparam logic [BACKOFF_W-1:0] BACKOFF_RESET = 16'd15;
   localparam logic [NUM_STREAMS-1:0] ENABLE_RESET = '1;

   // register indexes on the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STRIDE_ZERO  = 3'd0,
      CSR_STRIDE_ONE   = 3'd1,
      CSR_STRIDE_TWO   = 3'd2,
      CSR_STRIDE_THREE = 3'd3,
      CSR_USAGE_LIMIT  = 3'd4,
      CSR_BACKOFF      = 3'd5,
      CSR_ENABLE       = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PICK,
      ST_SUM,
      ST_OVER,
      ST_LOWER,
      ST_STATUS,
      ST_DONE
   } state_type;

endpackage

### hdl/fair_share_stream_picker_unit.sv
// Top level of the fair-share stream picker: sequencer around one shared compare/add unit.
//
// Usage:
//   req_ channel carries one word per request: the current time in seconds and a
//   mask of streams that have work. rsp_ channel returns exactly one word per
//   request: granted flag, granted stream index and the mask of paused streams.
//   csr_ port writes strides, usage limit, backoff and stream enables; write only
//   while no request is in flight.
// Timing:
//   One stream is visited per cycle: a search pass scans every stream once and then
//   decides, and each empty pick pauses that stream and starts another pass (at most
//   5 passes). A grant adds the usage sum and limit check and then the usage update
//   sweep over all streams; the paused-mask sweep follows, and then the result is
//   loaded into the result register once that register is free.
//   req_ready is high only while the sequencer is idle.
// Reset: usage and pause times clear to zero, registers take their default
//   values, no result is pending.
// Stall: the result register holds its word until rsp_ready; a new request may
//   be accepted meanwhile, and its result waits in the sequencer until the
//   register frees up.
module fair_share_stream_picker_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [fssp_pkg::TIME_W-1:0]        req_now_seconds,
   input  logic [fssp_pkg::NUM_STREAMS-1:0]   req_has_work_mask,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_granted,
   output logic [fssp_pkg::STREAM_W-1:0]      rsp_stream_index,
   output logic [fssp_pkg::NUM_STREAMS-1:0]   rsp_paused_mask,
   input  logic                               csr_write_en,
   input  logic [fssp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [fssp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int N  = fssp_pkg::NUM_STREAMS;
   localparam int UW = fssp_pkg::USAGE_W;
   localparam int TW = fssp_pkg::TIME_W;
   localparam int SW = fssp_pkg::STREAM_W;

   fssp_pkg::state_type state_ff, state_in;

   // configuration
   logic [UW-1:0]                  stride_ff [N];
   logic [UW-1:0]                  limit_ff;
   logic [fssp_pkg::BACKOFF_W-1:0] backoff_ff;
   logic [N-1:0]                   enable_ff;

   // per-stream state
   logic [UW-1:0] usage_ff [N];
   logic [TW-1:0] pause_ff [N];

   // request context
   logic [TW-1:0] now_ff;
   logic [N-1:0]  work_ff;
   logic [N-1:0]  tried_ff;
   logic [N-1:0]  paused_ff;
   logic [SW-1:0] idx_ff;
   logic [SW-1:0] best_ff;
   logic          found_ff;
   logic [UW-1:0] best_usage_ff;
   logic          granted_ff;
   logic [UW:0]   sum_ff;
   logic [UW:0]   d_ff;
   logic          over_ff;

   // result register
   logic          rsp_valid_ff;
   logic          rsp_granted_ff;
   logic [SW-1:0] rsp_index_ff;
   logic [N-1:0]  rsp_paused_ff;

   logic          last_idx;
   logic          cur_paused;
   logic          cur_elig;
   logic          cur_better;
   logic [UW:0]   lower_v;
   logic [UW:0]   lower_in;
   logic          out_free;
   logic          load_rsp;

   assign last_idx   = (idx_ff == fssp_pkg::LAST_STREAM);
   assign cur_paused = (pause_ff[idx_ff] > now_ff);
   assign cur_elig   = enable_ff[idx_ff] & ~tried_ff[idx_ff] & ~cur_paused;
   // <= so that a tie goes to the later (higher) stream
   assign cur_better = ~found_ff | (usage_ff[idx_ff] <= best_usage_ff);
   assign out_free   = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      lower_v = (idx_ff == best_ff) ? sum_ff : {1'b0, usage_ff[idx_ff]};
      if (over_ff && (lower_v > d_ff)) begin
         lower_in = lower_v - d_ff;
      end else begin
         lower_in = lower_v;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fssp_pkg::ST_IDLE: begin
            if (req_valid) state_in = fssp_pkg::ST_SCAN;
         end
         fssp_pkg::ST_SCAN: begin
            if (last_idx) state_in = fssp_pkg::ST_PICK;
         end
         fssp_pkg::ST_PICK: begin
            if (!found_ff) begin
               state_in = fssp_pkg::ST_STATUS;
            end else if (work_ff[best_ff]) begin
               state_in = fssp_pkg::ST_SUM;
            end else begin
               state_in = fssp_pkg::ST_SCAN;
            end
         end
         fssp_pkg::ST_SUM:    state_in = fssp_pkg::ST_OVER;
         fssp_pkg::ST_OVER:   state_in = fssp_pkg::ST_LOWER;
         fssp_pkg::ST_LOWER: begin
            if (last_idx) state_in = fssp_pkg::ST_STATUS;
         end
         fssp_pkg::ST_STATUS: begin
            if (last_idx) state_in = fssp_pkg::ST_DONE;
         end
         fssp_pkg::ST_DONE: begin
            if (out_free) state_in = fssp_pkg::ST_IDLE;
         end
         default: state_in = fssp_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         fssp_pkg::ST_IDLE: req_ready = 1'b1;
         fssp_pkg::ST_DONE: load_rsp  = out_free;
         default: begin
            req_ready = 1'b0;
            load_rsp  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fssp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) stride_ff[i] <= fssp_pkg::STRIDE_RESET;
         limit_ff   <= fssp_pkg::LIMIT_RESET;
         backoff_ff <= fssp_pkg::BACKOFF_RESET;
         enable_ff  <= fssp_pkg::ENABLE_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            fssp_pkg::CSR_STRIDE_ZERO:  stride_ff[0] <= csr_wdata[UW-1:0];
            fssp_pkg::CSR_STRIDE_ONE:   stride_ff[1] <= csr_wdata[UW-1:0];
            fssp_pkg::CSR_STRIDE_TWO:   stride_ff[2] <= csr_wdata[UW-1:0];
            fssp_pkg::CSR_STRIDE_THREE: stride_ff[3] <= csr_wdata[UW-1:0];
            fssp_pkg::CSR_USAGE_LIMIT:  limit_ff     <= csr_wdata[UW-1:0];
            fssp_pkg::CSR_BACKOFF:      backoff_ff   <= csr_wdata[fssp_pkg::BACKOFF_W-1:0];
            fssp_pkg::CSR_ENABLE:       enable_ff    <= csr_wdata[N-1:0];
            default: ;
         endcase
      end
   end

   // per-stream state: usage and pause time
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            usage_ff[i] <= '0;
            pause_ff[i] <= '0;
         end
      end else begin
         if (state_ff == fssp_pkg::ST_PICK && found_ff && !work_ff[best_ff]) begin
            pause_ff[best_ff] <= now_ff + {{(TW-fssp_pkg::BACKOFF_W){1'b0}}, backoff_ff};
         end
         if (state_ff == fssp_pkg::ST_LOWER) begin
            usage_ff[idx_ff] <= lower_in[UW-1:0];
         end
      end
   end

   // request context and the shared compare/add unit
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff     <= '0;
         found_ff   <= 1'b0;
         granted_ff <= 1'b0;
         tried_ff   <= '0;
      end else begin
         case (state_ff)
            fssp_pkg::ST_IDLE: begin
               if (req_valid) begin
                  now_ff     <= req_now_seconds;
                  work_ff    <= req_has_work_mask;
                  tried_ff   <= '0;
                  found_ff   <= 1'b0;
                  granted_ff <= 1'b0;
                  best_ff    <= '0;
                  idx_ff     <= '0;
               end
            end
            fssp_pkg::ST_SCAN: begin
               if (cur_elig && cur_better) begin
                  found_ff      <= 1'b1;
                  best_ff       <= idx_ff;
                  best_usage_ff <= usage_ff[idx_ff];
               end
               idx_ff <= idx_ff + 1'b1;
            end
            fssp_pkg::ST_PICK: begin
               idx_ff <= '0;
               if (found_ff && work_ff[best_ff]) begin
                  granted_ff <= 1'b1;
               end else if (found_ff) begin
                  tried_ff[best_ff] <= 1'b1;
                  found_ff          <= 1'b0;
               end
            end
            fssp_pkg::ST_SUM: begin
               sum_ff <= {1'b0, best_usage_ff} + {1'b0, stride_ff[best_ff]};
            end
            fssp_pkg::ST_OVER: begin
               d_ff    <= sum_ff - {1'b0, limit_ff};
               over_ff <= (sum_ff > {1'b0, limit_ff});
               idx_ff  <= '0;
            end
            fssp_pkg::ST_LOWER: begin
               idx_ff <= idx_ff + 1'b1;
            end
            fssp_pkg::ST_STATUS: begin
               paused_ff[idx_ff] <= cur_paused;
               idx_ff            <= idx_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_granted_ff <= granted_ff;
         rsp_index_ff   <= granted_ff ? best_ff : '0;
         rsp_paused_ff  <= paused_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_stream_index = rsp_index_ff;
   assign rsp_paused_mask  = rsp_paused_ff;

endmodule
